// ===== hdl/tic_pkg.sv =====
// shared constants, types and the square root step for the triangle incenter unit
`default_nettype none
package tic_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 8;

  // squared distance, padded to an even width for two-bit digits
  localparam int D2W       = 2 * COORD_BITS + 2;
  localparam int ROOTW     = COORD_BITS + 1 + FRAC_BITS;
  localparam int REMW      = ROOTW + 3;
  localparam int WSUMW     = ROOTW + 2;
  localparam int PRODW     = COORD_BITS + ROOTW;
  localparam int SUMW      = PRODW + 2;
  localparam int SQ_STEPS  = ROOTW;
  localparam int DIV_STEPS = COORD_BITS;
  localparam int NSTAGES   = 3 + SQ_STEPS + 2 + DIV_STEPS;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [ROOTW-1:0]      root_t;
  typedef logic [REMW-1:0]       rem_t;
  typedef logic [D2W-1:0]        d2_t;
  typedef logic [SUMW-1:0]       sum_t;
  typedef logic [WSUMW-1:0]      wsum_t;

  typedef struct packed {
    rem_t  rem;
    root_t root;
  } sq_t;

  typedef struct packed {
    logic [2:0][COORD_BITS-1:0] x;
    logic [2:0][COORD_BITS-1:0] y;
  } vtx_t;

  // one digit of the restoring square root
  function automatic sq_t sqrt_step(sq_t s, logic [1:0] pair);
    rem_t rem2;
    rem_t trial;
    sq_t  r;
    rem2  = {s.rem[REMW-3:0], pair};
    trial = REMW'({s.root, 2'b01});
    if (rem2 >= trial) begin
      r.rem  = rem2 - trial;
      r.root = {s.root[ROOTW-2:0], 1'b1};
    end else begin
      r.rem  = rem2;
      r.root = {s.root[ROOTW-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/triangle_incenter_unit.sv =====
// triangle incenter unit: pipelined side lengths, weighted sum and division
// throughput: one triangle per cycle; one stage per square root digit and per
// quotient bit sets the depth
// the whole pipeline holds while the result waits and out_ready is low
// synchronous active-high reset clears all valid bits, data registers are not reset
`default_nettype none
module triangle_incenter_unit (
  input  wire  logic                          clk,
  input  wire  logic                          rst,
  input  wire  logic                          in_valid,
  output logic                                in_ready,
  input  wire  logic [tic_pkg::COORD_BITS-1:0] ax,
  input  wire  logic [tic_pkg::COORD_BITS-1:0] ay,
  input  wire  logic [tic_pkg::COORD_BITS-1:0] bx,
  input  wire  logic [tic_pkg::COORD_BITS-1:0] by_coord,
  input  wire  logic [tic_pkg::COORD_BITS-1:0] cx_in,
  input  wire  logic [tic_pkg::COORD_BITS-1:0] cy_in,
  output logic                                out_valid,
  input  wire  logic                          out_ready,
  output logic [tic_pkg::COORD_BITS-1:0]      center_x,
  output logic [tic_pkg::COORD_BITS-1:0]      center_y,
  output logic                                degenerate
);

  localparam int CB = tic_pkg::COORD_BITS;
  localparam int NS = tic_pkg::NSTAGES;

  logic [NS-1:0] vld;
  logic          en;

  assign en       = !vld[NS-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  function automatic tic_pkg::coord_t adiff(tic_pkg::coord_t p, tic_pkg::coord_t q);
    return (p >= q) ? (p - q) : (q - p);
  endfunction

  // stage 1: register vertices and differences per side
  tic_pkg::vtx_t   v1;
  tic_pkg::coord_t dx1 [3];
  tic_pkg::coord_t dy1 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      v1.x   <= {cx_in, bx, ax};
      v1.y   <= {cy_in, by_coord, ay};
      dx1[0] <= adiff(bx, cx_in);
      dy1[0] <= adiff(by_coord, cy_in);
      dx1[1] <= adiff(ax, cx_in);
      dy1[1] <= adiff(ay, cy_in);
      dx1[2] <= adiff(ax, bx);
      dy1[2] <= adiff(ay, by_coord);
    end
  end

  // stage 2: squares
  tic_pkg::vtx_t     v2;
  logic [2*CB-1:0]   sqx2 [3];
  logic [2*CB-1:0]   sqy2 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      v2 <= v1;
      for (int k = 0; k < 3; k++) begin
        sqx2[k] <= (2*CB)'(dx1[k]) * (2*CB)'(dx1[k]);
        sqy2[k] <= (2*CB)'(dy1[k]) * (2*CB)'(dy1[k]);
      end
    end
  end

  // stage 3: squared distances
  tic_pkg::vtx_t v3;
  tic_pkg::d2_t  d2_3 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      v3 <= v2;
      for (int k = 0; k < 3; k++) begin
        d2_3[k] <= tic_pkg::D2W'(sqx2[k]) + tic_pkg::D2W'(sqy2[k]);
      end
    end
  end

  // square root, one digit per stage for all three sides
  tic_pkg::vtx_t vs  [tic_pkg::SQ_STEPS];
  tic_pkg::d2_t  ds  [tic_pkg::SQ_STEPS][3];
  tic_pkg::sq_t  sqs [tic_pkg::SQ_STEPS][3];

  for (genvar s = 0; s < tic_pkg::SQ_STEPS; s++) begin : g_sqrt
    tic_pkg::vtx_t vin;
    tic_pkg::d2_t  din [3];
    tic_pkg::sq_t  qin [3];
    logic [1:0]    pair [3];

    if (s == 0) begin : g_first
      always_comb begin
        vin = v3;
        for (int k = 0; k < 3; k++) begin
          din[k] = d2_3[k];
          qin[k] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        vin = vs[s-1];
        for (int k = 0; k < 3; k++) begin
          din[k] = ds[s-1][k];
          qin[k] = sqs[s-1][k];
        end
      end
    end

    if (s <= CB) begin : g_int
      localparam int SH = 2 * (CB - s);
      always_comb begin
        for (int k = 0; k < 3; k++) begin
          pair[k] = din[k][SH+1:SH];
        end
      end
    end else begin : g_frac
      always_comb begin
        for (int k = 0; k < 3; k++) begin
          pair[k] = 2'b00;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        vs[s] <= vin;
        for (int k = 0; k < 3; k++) begin
          ds[s][k]  <= din[k];
          sqs[s][k] <= tic_pkg::sqrt_step(qin[k], pair[k]);
        end
      end
    end
  end

  // weight products and weight sum
  localparam int SL = tic_pkg::SQ_STEPS - 1;
  tic_pkg::vtx_t                  vm;
  logic [tic_pkg::PRODW-1:0]      px [3];
  logic [tic_pkg::PRODW-1:0]      py [3];
  tic_pkg::wsum_t                 wsm;

  always_ff @(posedge clk) begin
    if (en) begin
      vm  <= vs[SL];
      wsm <= tic_pkg::WSUMW'(sqs[SL][0].root) + tic_pkg::WSUMW'(sqs[SL][1].root)
           + tic_pkg::WSUMW'(sqs[SL][2].root);
      for (int k = 0; k < 3; k++) begin
        px[k] <= tic_pkg::PRODW'(vs[SL].x[k]) * tic_pkg::PRODW'(sqs[SL][k].root);
        py[k] <= tic_pkg::PRODW'(vs[SL].y[k]) * tic_pkg::PRODW'(sqs[SL][k].root);
      end
    end
  end

  // weighted sums
  tic_pkg::sum_t   sxs;
  tic_pkg::sum_t   sys;
  tic_pkg::wsum_t  wss;
  logic            dgs;
  tic_pkg::coord_t axs;
  tic_pkg::coord_t ays;

  always_ff @(posedge clk) begin
    if (en) begin
      sxs <= tic_pkg::SUMW'(px[0]) + tic_pkg::SUMW'(px[1]) + tic_pkg::SUMW'(px[2]);
      sys <= tic_pkg::SUMW'(py[0]) + tic_pkg::SUMW'(py[1]) + tic_pkg::SUMW'(py[2]);
      wss <= wsm;
      dgs <= (wsm == '0);
      axs <= vm.x[0];
      ays <= vm.y[0];
    end
  end

  // restoring division, one quotient bit per stage, quotient fits in CB bits
  tic_pkg::sum_t   rx [tic_pkg::DIV_STEPS];
  tic_pkg::sum_t   ry [tic_pkg::DIV_STEPS];
  tic_pkg::coord_t qx [tic_pkg::DIV_STEPS];
  tic_pkg::coord_t qy [tic_pkg::DIV_STEPS];
  tic_pkg::wsum_t  wd [tic_pkg::DIV_STEPS];
  logic            dd [tic_pkg::DIV_STEPS];
  tic_pkg::coord_t ad [tic_pkg::DIV_STEPS];
  tic_pkg::coord_t bd [tic_pkg::DIV_STEPS];

  for (genvar j = 0; j < tic_pkg::DIV_STEPS; j++) begin : g_div
    localparam int B = tic_pkg::DIV_STEPS - 1 - j;
    tic_pkg::sum_t   rxi, ryi, dvs;
    tic_pkg::coord_t qxi, qyi;
    tic_pkg::wsum_t  wi;
    logic            di;
    tic_pkg::coord_t ai, bi;

    if (j == 0) begin : g_first
      always_comb begin
        rxi = sxs; ryi = sys; qxi = '0; qyi = '0;
        wi = wss; di = dgs; ai = axs; bi = ays;
      end
    end else begin : g_next
      always_comb begin
        rxi = rx[j-1]; ryi = ry[j-1]; qxi = qx[j-1]; qyi = qy[j-1];
        wi = wd[j-1]; di = dd[j-1]; ai = ad[j-1]; bi = bd[j-1];
      end
    end

    assign dvs = tic_pkg::SUMW'(wi) << B;

    always_ff @(posedge clk) begin
      if (en) begin
        wd[j] <= wi;
        dd[j] <= di;
        ad[j] <= ai;
        bd[j] <= bi;
        if (rxi >= dvs) begin
          rx[j] <= rxi - dvs;
          qx[j] <= qxi | (CB'(1) << B);
        end else begin
          rx[j] <= rxi;
          qx[j] <= qxi;
        end
        if (ryi >= dvs) begin
          ry[j] <= ryi - dvs;
          qy[j] <= qyi | (CB'(1) << B);
        end else begin
          ry[j] <= ryi;
          qy[j] <= qyi;
        end
      end
    end
  end

  localparam int DL = tic_pkg::DIV_STEPS - 1;

  assign out_valid  = vld[NS-1];
  assign center_x   = dd[DL] ? ad[DL] : qx[DL];
  assign center_y   = dd[DL] ? bd[DL] : qy[DL];
  assign degenerate = dd[DL];

`ifndef ASSERT_OFF
  // zero weights give zero weighted sums
  a_deg_zero_sum: assert property (@(posedge clk) disable iff (rst)
    dgs |-> (sxs == '0 && sys == '0))
    else $error("degenerate triangle with nonzero weighted sum");

  // division leaves a remainder below the divisor
  a_rem_small: assert property (@(posedge clk) disable iff (rst)
    (vld[NS-1] && !dd[DL]) |-> (rx[DL] < tic_pkg::SUMW'(wd[DL])
                                && ry[DL] < tic_pkg::SUMW'(wd[DL])))
    else $error("division remainder not below weight sum");

  // a held result keeps the whole pipeline frozen
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(vld)))
    else $error("pipeline moved while result was stalled");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("valid bits not cleared by reset");
`endif

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// self-checking testbench for the triangle incenter unit
`timescale 1ns / 100ps
module tb_top;

  typedef struct {
    tic_pkg::coord_t ax, ay, bx, by, cx, cy;
  } tri_t;

  typedef struct {
    tic_pkg::coord_t cx, cy;
    logic            degen;
  } center_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  tic_pkg::coord_t ax = '0, ay = '0, bx = '0, by_coord = '0, cx_in = '0, cy_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tic_pkg::coord_t center_x, center_y;
  logic degenerate;
  logic in_fire = 1'b0;

  tri_t    tri_q[$];
  center_t center_q[$];
  int      mismatches = 0;
  bit      stim_done = 1'b0;
  bit      quiet_tail = 1'b0;
  int      send_hold = 0, recv_hold = 0;

  triangle_incenter_unit dut (
    .clk, .rst, .in_valid, .in_ready, .ax, .ay, .bx, .by_coord, .cx_in, .cy_in,
    .out_valid, .out_ready, .center_x, .center_y, .degenerate
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // floor(sqrt(d2) * 2^FRAC_BITS) by restoring digit recurrence
  function automatic longint unsigned fixed_len(longint unsigned d2);
    longint unsigned rem, root, trial, rad;
    rem = 0;
    root = 0;
    rad = d2 << (2 * tic_pkg::FRAC_BITS);
    for (int i = tic_pkg::COORD_BITS + tic_pkg::FRAC_BITS; i >= 0; i--) begin
      rem = (rem << 2) | ((rad >> (2 * i)) & 3);
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic longint unsigned side(tic_pkg::coord_t x0, tic_pkg::coord_t y0,
                                           tic_pkg::coord_t x1, tic_pkg::coord_t y1);
    longint unsigned dx, dy;
    dx = (x0 >= x1) ? x0 - x1 : x1 - x0;
    dy = (y0 >= y1) ? y0 - y1 : y1 - y0;
    return fixed_len(dx * dx + dy * dy);
  endfunction

  function automatic center_t incenter(tri_t t);
    longint unsigned wa, wb, wc, wsum;
    center_t r;
    wa = side(t.bx, t.by, t.cx, t.cy);
    wb = side(t.ax, t.ay, t.cx, t.cy);
    wc = side(t.ax, t.ay, t.bx, t.by);
    wsum = wa + wb + wc;
    if (wsum == 0) begin
      r.cx = t.ax;
      r.cy = t.ay;
      r.degen = 1'b1;
    end else begin
      r.cx = tic_pkg::coord_t'((t.ax * wa + t.bx * wb + t.cx * wc) / wsum);
      r.cy = tic_pkg::coord_t'((t.ay * wa + t.by * wb + t.cy * wc) / wsum);
      r.degen = 1'b0;
    end
    return r;
  endfunction

  function automatic tic_pkg::coord_t rnd_coord();
    case ($urandom_range(0, 5))
      0: return tic_pkg::coord_t'($urandom_range(0, 3));
      1: return tic_pkg::coord_t'(4095 - $urandom_range(0, 3));
      default: return tic_pkg::coord_t'($urandom);
    endcase
  endfunction

  task automatic add_tri(tic_pkg::coord_t a0, tic_pkg::coord_t a1, tic_pkg::coord_t b0,
                         tic_pkg::coord_t b1, tic_pkg::coord_t c0, tic_pkg::coord_t c1);
    tri_t t;
    t.ax = a0; t.ay = a1; t.bx = b0; t.by = b1; t.cx = c0; t.cy = c1;
    tri_q.push_back(t);
  endtask

  initial begin
    tic_pkg::coord_t p, q, s;
    // directed: corners, coincident, collinear, tiny and huge triangles
    add_tri(0, 0, 0, 0, 0, 0);
    add_tri(4095, 4095, 4095, 4095, 4095, 4095);
    add_tri(1234, 567, 1234, 567, 1234, 567);
    add_tri(0, 0, 4095, 0, 0, 4095);
    add_tri(4095, 4095, 0, 4095, 4095, 0);
    add_tri(0, 0, 4095, 4095, 0, 4095);
    add_tri(0, 0, 4095, 4095, 2048, 2048);
    add_tri(0, 0, 1, 0, 2, 0);
    add_tri(5, 5, 5, 5, 6, 6);
    add_tri(0, 0, 0, 0, 4095, 4095);
    add_tri(4095, 0, 0, 4095, 4095, 0);
    add_tri(0, 0, 1, 0, 0, 1);
    add_tri(2730, 1365, 1365, 2730, 4095, 4095);
    add_tri(100, 200, 300, 200, 200, 373);
    add_tri(4094, 1, 1, 4094, 2047, 2048);
    add_tri(12'haaa, 12'h555, 12'h555, 12'haaa, 12'hfff, 12'h000);
    for (int i = 0; i < 1100; i++) begin
      case ($urandom_range(0, 9))
        0: begin
          p = rnd_coord(); q = rnd_coord();
          add_tri(p, q, p, q, p, q);
        end
        1: begin
          p = rnd_coord(); q = rnd_coord(); s = rnd_coord();
          add_tri(p, q, s, q, rnd_coord(), q);
        end
        2: begin
          p = rnd_coord(); q = rnd_coord();
          add_tri(p, q, p + tic_pkg::coord_t'($urandom_range(0, 2)), q,
                  p, q + tic_pkg::coord_t'($urandom_range(0, 2)));
        end
        default: add_tri(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                         rnd_coord(), rnd_coord());
      endcase
    end
    stim_done = 1'b1;
  end

  // remember whether the request was taken at the last rising edge
  always @(posedge clk) begin
    in_fire <= !rst && in_valid && in_ready;
  end

  // driver: requests change on the falling edge
  always @(negedge clk) begin
    tri_t t;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (send_hold > 0) begin
        send_hold <= send_hold - 1;
        in_valid <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 15) == 0) begin
        send_hold <= $urandom_range(1, 18) - 1;
        in_valid <= 1'b0;
      end else if (tri_q.size() > 0) begin
        t = tri_q.pop_front();
        center_q.push_back(incenter(t));
        ax <= t.ax; ay <= t.ay; bx <= t.bx;
        by_coord <= t.by; cx_in <= t.cx; cy_in <= t.cy;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      out_ready <= 1'b0;
    end else if (!quiet_tail && $urandom_range(0, 15) == 0) begin
      recv_hold <= $urandom_range(1, 18) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
    if (stim_done && tri_q.size() < 150) quiet_tail <= 1'b1;
  end

  // expectation is pushed at drive time, so a request not yet accepted
  // sits at the back of the queue and cannot be matched early
  always @(posedge clk) begin
    center_t e;
    if (!rst && out_valid && out_ready) begin
      if (center_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result x=%0d y=%0d", center_x, center_y);
      end else begin
        e = center_q.pop_front();
        if (center_x !== e.cx || center_y !== e.cy || degenerate !== e.degen) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp x=%0d y=%0d deg=%0b, got x=%0d y=%0d deg=%0b",
                     e.cx, e.cy, e.degen, center_x, center_y, degenerate);
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done && tri_q.size() == 0 && !(in_valid && !in_ready)
          && center_q.size() == 0);
    repeat (3 * tic_pkg::NSTAGES) @(posedge clk);
    if (mismatches == 0 && center_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
